FILE: hdl/fpdc_pkg.sv
// ----------------------------------------------------------------------------
// fpdc_pkg
// Shared types, constants and tables of the fuzzy PD temperature controller:
// register indexes, clamp codes, rule base and the exp(-x) lookup table.
// ----------------------------------------------------------------------------
package fpdc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ERROR_GAIN     = 3'd0;
    localparam logic [2:0] REG_CHANGE_GAIN    = 3'd1;
    localparam logic [2:0] REG_OUTPUT_GAIN    = 3'd2;
    localparam logic [2:0] REG_INVERSE_SPREAD = 3'd3;
    localparam logic [2:0] REG_CENTER_STEP    = 3'd4;
    localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [15:0] RST_ERROR_GAIN     = 16'd4369;
    localparam logic [15:0] RST_CHANGE_GAIN    = 16'd4369;
    localparam logic [9:0]  RST_OUTPUT_GAIN    = 10'd250;
    localparam logic [15:0] RST_INVERSE_SPREAD = 16'd16384;
    localparam logic [13:0] RST_CENTER_STEP    = 14'd8192;
    localparam logic [15:0] RST_DRIVE_LIMIT    = 16'd20480;

    // Clamp status codes
    localparam logic [1:0] CLAMP_NONE  = 2'd0;
    localparam logic [1:0] CLAMP_ZERO  = 2'd1;
    localparam logic [1:0] CLAMP_LIMIT = 2'd2;

    // Fuzzy sets and rules
    localparam int SET_COUNT  = 5;
    localparam int RULE_COUNT = 16;
    localparam int SET_W      = 3;
    localparam int RULE_W     = 4;

    typedef logic [SET_W-1:0] set_idx_t;
    typedef set_idx_t rule_sets_t [RULE_COUNT];

    // Zero-based set of each rule: error, change of error, output
    localparam rule_sets_t RULE_E  = '{3'd3, 3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd1,
                                       3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd4, 3'd3, 3'd2};
    localparam rule_sets_t RULE_CE = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
                                       3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4};
    localparam rule_sets_t RULE_Z  = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd4, 3'd3, 3'd2, 3'd1,
                                       3'd0, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3};

    // Shared multiplier and divider widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 36;
    localparam int DEN_W   = 20;
    localparam int QUO_W   = 16;

    // exp(-16 i / depth) table, Q1.15
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

    typedef logic [15:0] exp_table_t [EXP_TABLE_DEPTH];

    // Long division for the table build, one quotient bit per step
    function automatic longint unsigned const_udiv(input longint unsigned n,
                                                   input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Build the table from a truncated Taylor series of the step ratio
    function automatic exp_table_t build_exp_table();
        longint unsigned t;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned r;
        longint unsigned v;
        exp_table_t      tab;
        t   = 64'd1 << 32;
        pos = t;
        neg = 64'd0;
        for (int k = 1; k <= 14; k++)
        begin
            t = const_udiv(t * 64'd16, 64'(EXP_TABLE_DEPTH) * 64'(k));
            if ((k % 2) == 1)
                neg = neg + t;
            else
                pos = pos + t;
        end
        r = pos - neg;
        v = 64'd1 << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            if (i > 0)
                v = (v * r + (64'd1 << 31)) >> 32;
            tab[i] = 16'((v + 64'd65536) >> 17);
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

FILE: hdl/fpdc_if.sv
// ----------------------------------------------------------------------------
// fpdc_if
// Valid/ready channels of the controller: sample input and drive result.
// ----------------------------------------------------------------------------
interface fpdc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] reference;
    logic [15:0] measured;
    logic        restart;

    modport source (output valid, output reference, output measured, output restart,
                    input ready);
    modport sink   (input valid, input reference, input measured, input restart,
                    output ready);
endinterface

interface fpdc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        drive;
    logic signed [15:0] fuzzy_output;
    logic               no_weight;
    logic [1:0]         clamped;

    modport source (output valid, output drive, output fuzzy_output, output no_weight,
                    output clamped, input ready);
    modport sink   (input valid, input drive, input fuzzy_output, input no_weight,
                    input clamped, output ready);
endinterface

FILE: hdl/fpdc_div.sv
// ----------------------------------------------------------------------------
// fpdc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QUO_W bits, so the top numerator bits start the remainder.
// ----------------------------------------------------------------------------
module fpdc_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fpdc_pkg::NUM_W-1:0]     num,
    input  logic [fpdc_pkg::DEN_W-1:0]     den,
    output logic                           done,
    output logic [fpdc_pkg::QUO_W-1:0]     quo
);

    logic                          run_reg;
    logic                          done_reg;
    logic [3:0]                    cnt_reg;
    logic [fpdc_pkg::DEN_W-1:0]    rem_reg;
    logic [fpdc_pkg::QUO_W-1:0]    quo_reg;
    logic [fpdc_pkg::DEN_W:0]      trial;
    logic                          fits;

    // Bring down the next numerator bit and try the subtract
    assign trial = {rem_reg, quo_reg[fpdc_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, den};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 4'd15);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    run_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[fpdc_pkg::NUM_W-1 -: fpdc_pkg::DEN_W];
            quo_reg <= num[fpdc_pkg::QUO_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? fpdc_pkg::DEN_W'(trial - {1'b0, den})
                            : trial[fpdc_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[fpdc_pkg::QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: hdl/fuzzy_pd_temperature_controller_unit.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_temperature_controller_unit
// Fuzzy PD temperature controller with Gaussian sets, min rule firing and
// weighted-average defuzzification, built around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a reference and a measured temperature (Q8.8) and a restart
//   flag; one beat is one sample. out_ch returns one beat per sample with the
//   clamped drive, the raw fuzzy output, a zero-weight flag and clamp status.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wr_data while
//   the block is idle; an unknown index is ignored.
// Sequence:
//   A sample runs through the gain scaling, ten membership degrees (each
//   through the shared multiplier and the exp table), the rules, the
//   weighted sum, the divider and the sign and output scaling. With zero
//   rule weight the divider is skipped. in_ch.ready is high only when the
//   sequencer is idle, so one sample is in work at a time.
//   A finished result waits in the output register while the next sample is
//   taken; if the receiver still stalls when that sample finishes, the
//   sequencer holds until the register is free.
// Reset:
//   Registers return to their defaults, the previous error is forgotten and
//   the first sample after reset uses a zero change of error.
// ----------------------------------------------------------------------------
module fuzzy_pd_temperature_controller_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    fpdc_in_if.sink                             in_ch,
    fpdc_out_if.source                          out_ch,
    input  logic                                cfg_wr_en,
    input  logic [fpdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fpdc_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int PW = fpdc_pkg::PROD_W;
    localparam int AW = fpdc_pkg::MUL_A_W;
    localparam int BW = fpdc_pkg::MUL_B_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ME   = 4'd1;
    localparam logic [3:0] S_MC   = 4'd2;
    localparam logic [3:0] S_RC   = 4'd3;
    localparam logic [3:0] S_D1   = 4'd4;
    localparam logic [3:0] S_D2   = 4'd5;
    localparam logic [3:0] S_D3   = 4'd6;
    localparam logic [3:0] S_RULE = 4'd7;
    localparam logic [3:0] S_MW   = 4'd8;
    localparam logic [3:0] S_DIVI = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_FO   = 4'd11;
    localparam logic [3:0] S_PM   = 4'd12;
    localparam logic [3:0] S_DRV  = 4'd13;

    logic [3:0]                   state_reg;
    logic [3:0]                   state_next;

    // Configuration
    logic [15:0]                  error_gain_reg;
    logic [15:0]                  change_gain_reg;
    logic [9:0]                   output_gain_reg;
    logic [15:0]                  inverse_spread_reg;
    logic [13:0]                  center_step_reg;
    logic [15:0]                  drive_limit_reg;

    // Sample state
    logic signed [16:0]           prev_err_reg;
    logic                         have_prev_reg;
    logic signed [16:0]           e_reg;
    logic signed [17:0]           ce_reg;
    logic signed [16:0]           e_in;
    logic signed [17:0]           ce_in;

    // Shared multiplier
    logic signed [AW-1:0]         mul_a;
    logic signed [BW-1:0]         mul_b;
    logic signed [PW-1:0]         mul_p;
    logic signed [PW-1:0]         prod_reg;

    // Fuzzification
    logic signed [24:0]           xe_reg;
    logic signed [24:0]           xce_reg;
    logic [fpdc_pkg::SET_W-1:0]   set_reg;
    logic                         side_reg;
    logic                         far_reg;
    logic [15:0]                  mu_e_reg [fpdc_pkg::SET_COUNT];
    logic [15:0]                  mu_ce_reg [fpdc_pkg::SET_COUNT];
    logic signed [24:0]           x_sel;
    logic signed [15:0]           centre;
    logic signed [25:0]           diff;
    logic [25:0]                  dmag;
    logic [27:0]                  d12;
    logic [15:0]                  mu;

    // Rules
    logic [fpdc_pkg::RULE_W-1:0]  rule_reg;
    logic [19:0]                  sphi_reg;
    logic signed [21:0]           w_reg;
    logic [15:0]                  phi_e;
    logic [15:0]                  phi_ce;
    logic [15:0]                  phi;
    logic signed [21:0]           w_term;

    // Defuzzification
    logic                         neg_reg;
    logic                         nw_reg;
    logic signed [15:0]           fo_reg;
    logic [PW-1:0]                pmag;
    logic                         div_start;
    logic                         div_done;
    logic [fpdc_pkg::QUO_W-1:0]   div_quo;
    logic [fpdc_pkg::NUM_W-1:0]   div_num;
    logic [24:0]                  drive_full;
    logic                         out_free;

    // Output register
    logic                         out_valid_reg;
    logic [15:0]                  drive_reg;
    logic signed [15:0]           fo_out_reg;
    logic                         nw_out_reg;
    logic [1:0]                   clamped_reg;

    // Round a gain product to Q.14, half away from zero
    function automatic logic signed [24:0] round_gain(input logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        logic [PW-1:0] r;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        r = (m + PW'(512)) >> 10;
        return p[PW-1] ? 25'(-$signed(r[24:0])) : $signed(r[24:0]);
    endfunction

    // Set centre (k - 2) * step
    function automatic logic signed [15:0] centre_of(input logic [fpdc_pkg::SET_W-1:0] k,
                                                     input logic [13:0] step);
        logic signed [15:0] one;
        logic signed [15:0] two;
        logic signed [15:0] c;
        one = $signed({2'b00, step});
        two = $signed({1'b0, step, 1'b0});
        case (k)
            3'd0:    c = -two;
            3'd1:    c = -one;
            3'd3:    c = one;
            3'd4:    c = two;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // Input handshake and error terms
    assign in_ch.ready = (state_reg == S_IDLE);
    assign e_in  = $signed({1'b0, in_ch.reference}) - $signed({1'b0, in_ch.measured});
    assign ce_in = (!in_ch.restart && have_prev_reg) ? 18'(e_in) - 18'(prev_err_reg)
                                                     : 18'sd0;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_gain_reg     <= fpdc_pkg::RST_ERROR_GAIN;
            change_gain_reg    <= fpdc_pkg::RST_CHANGE_GAIN;
            output_gain_reg    <= fpdc_pkg::RST_OUTPUT_GAIN;
            inverse_spread_reg <= fpdc_pkg::RST_INVERSE_SPREAD;
            center_step_reg    <= fpdc_pkg::RST_CENTER_STEP;
            drive_limit_reg    <= fpdc_pkg::RST_DRIVE_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fpdc_pkg::REG_ERROR_GAIN:     error_gain_reg     <= cfg_wr_data;
                fpdc_pkg::REG_CHANGE_GAIN:    change_gain_reg    <= cfg_wr_data;
                fpdc_pkg::REG_OUTPUT_GAIN:    output_gain_reg    <= cfg_wr_data[9:0];
                fpdc_pkg::REG_INVERSE_SPREAD: inverse_spread_reg <= cfg_wr_data;
                fpdc_pkg::REG_CENTER_STEP:    center_step_reg    <= cfg_wr_data[13:0];
                fpdc_pkg::REG_DRIVE_LIMIT:    drive_limit_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Membership distance operands
    assign x_sel  = side_reg ? xce_reg : xe_reg;
    assign centre = centre_of(set_reg, center_step_reg);
    assign diff   = 26'(x_sel) - 26'(centre);
    assign dmag   = diff[25] ? 26'(-diff) : 26'(diff);
    assign d12    = 28'((prod_reg[41:0] + 42'd8192) >> 14);
    assign mu     = far_reg ? 16'd0
                            : fpdc_pkg::EXP_TABLE[prod_reg[27 -: fpdc_pkg::EXP_IDX_W]];

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ME:
            begin
                mul_a = AW'(e_reg);
                mul_b = $signed({7'b0, error_gain_reg});
            end
            S_MC:
            begin
                mul_a = AW'(ce_reg);
                mul_b = $signed({7'b0, change_gain_reg});
            end
            S_D1:
            begin
                mul_a = $signed({1'b0, dmag[24:0]});
                mul_b = $signed({7'b0, inverse_spread_reg});
            end
            S_D2:
            begin
                mul_a = $signed({12'b0, d12[13:0]});
                mul_b = $signed({9'b0, d12[13:0]});
            end
            S_MW:
            begin
                mul_a = AW'(w_reg);
                mul_b = $signed({9'b0, center_step_reg});
            end
            S_PM:
            begin
                mul_a = AW'(fo_reg);
                mul_b = $signed({13'b0, output_gain_reg});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Rule firing strength and weighted output term
    assign phi_e  = mu_e_reg[fpdc_pkg::RULE_E[rule_reg]];
    assign phi_ce = mu_ce_reg[fpdc_pkg::RULE_CE[rule_reg]];
    assign phi    = (phi_e < phi_ce) ? phi_e : phi_ce;

    always_comb
    begin
        case (fpdc_pkg::RULE_Z[rule_reg])
            3'd0:    w_term = -$signed({5'b0, phi, 1'b0});
            3'd1:    w_term = -$signed({6'b0, phi});
            3'd3:    w_term = $signed({6'b0, phi});
            3'd4:    w_term = $signed({5'b0, phi, 1'b0});
            default: w_term = 22'sd0;
        endcase
    end

    // Divider operands
    assign pmag      = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign div_num   = pmag[fpdc_pkg::NUM_W-1:0] + fpdc_pkg::NUM_W'(sphi_reg >> 1);
    assign div_start = (state_reg == S_DIVI) && (sphi_reg != 20'd0);

    fpdc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sphi_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign drive_full = 25'((prod_reg[25:0] + 26'd2) >> 2);
    assign out_free   = !out_valid_reg || out_ch.ready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_ME;
            S_ME:   state_next = S_MC;
            S_MC:   state_next = S_RC;
            S_RC:   state_next = S_D1;
            S_D1:   state_next = S_D2;
            S_D2:   state_next = S_D3;
            S_D3:   state_next = (side_reg && (set_reg == 3'(fpdc_pkg::SET_COUNT - 1)))
                                 ? S_RULE : S_D1;
            S_RULE: if (rule_reg == fpdc_pkg::RULE_W'(fpdc_pkg::RULE_COUNT - 1))
                        state_next = S_MW;
            S_MW:   state_next = S_DIVI;
            S_DIVI: state_next = (sphi_reg == 20'd0) ? S_PM : S_DIV;
            S_DIV:  if (div_done) state_next = S_FO;
            S_FO:   state_next = S_PM;
            S_PM:   state_next = S_DRV;
            S_DRV:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_ch.valid && in_ch.ready)
            begin
                prev_err_reg  <= e_in;
                have_prev_reg <= 1'b1;
            end
            if ((state_reg == S_DRV) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                e_reg  <= e_in;
                ce_reg <= ce_in;
            end
            S_ME, S_D1, S_D2, S_MW, S_PM:
            begin
                prod_reg <= mul_p;
            end
            S_MC:
            begin
                prod_reg <= mul_p;
                xe_reg   <= round_gain(prod_reg);
            end
            S_RC:
            begin
                xce_reg  <= round_gain(prod_reg);
                set_reg  <= '0;
                side_reg <= 1'b0;
                rule_reg <= '0;
                sphi_reg <= '0;
                w_reg    <= '0;
            end
            S_D3:
            begin
                if (side_reg)
                    mu_ce_reg[set_reg] <= mu;
                else
                    mu_e_reg[set_reg] <= mu;
                side_reg <= !side_reg;
                if (side_reg)
                    set_reg <= set_reg + 3'd1;
            end
            S_RULE:
            begin
                sphi_reg <= sphi_reg + 20'(phi);
                w_reg    <= w_reg + w_term;
                rule_reg <= rule_reg + fpdc_pkg::RULE_W'(1);
            end
            S_DIVI:
            begin
                neg_reg <= prod_reg[PW-1];
                nw_reg  <= (sphi_reg == 20'd0);
                fo_reg  <= '0;
            end
            S_FO:
            begin
                fo_reg <= neg_reg ? -$signed(div_quo) : $signed(div_quo);
            end
            default: ;
        endcase
        if (state_reg == S_D2)
            far_reg <= |d12[27:14];
    end

    // Drive scaling, clamp and output load
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DRV) && out_free)
        begin
            fo_out_reg <= fo_reg;
            nw_out_reg <= nw_reg;
            if (prod_reg[PW-1])
            begin
                drive_reg   <= 16'd0;
                clamped_reg <= fpdc_pkg::CLAMP_ZERO;
            end
            else if (drive_full > 25'(drive_limit_reg))
            begin
                drive_reg   <= drive_limit_reg;
                clamped_reg <= fpdc_pkg::CLAMP_LIMIT;
            end
            else
            begin
                drive_reg   <= drive_full[15:0];
                clamped_reg <= fpdc_pkg::CLAMP_NONE;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.drive        = drive_reg;
    assign out_ch.fuzzy_output = fo_out_reg;
    assign out_ch.no_weight    = nw_out_reg;
    assign out_ch.clamped      = clamped_reg;

endmodule

FILE: hdl/fpdc_checker.sv
// ----------------------------------------------------------------------------
// fpdc_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module fpdc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        drive,
    input logic signed [15:0] fuzzy_output,
    input logic               no_weight,
    input logic [1:0]         clamped
);

    // One sample at a time: ready drops after an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    // Zero weight gives an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_weight |-> drive == 16'd0 && fuzzy_output == 16'sd0
                                   && clamped == fpdc_pkg::CLAMP_NONE)
        else $error("zero-weight result not cleared");

    // Clamp at zero only for a negative fuzzy output, with zero drive
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped == fpdc_pkg::CLAMP_ZERO |-> drive == 16'd0
                                                       && fuzzy_output < 16'sd0)
        else $error("clamp at zero inconsistent");

    // Clamp code stays within its codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> clamped == fpdc_pkg::CLAMP_NONE || clamped == fpdc_pkg::CLAMP_ZERO
                      || clamped == fpdc_pkg::CLAMP_LIMIT)
        else $error("bad clamp code");

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(fuzzy_output))
        else $error("stalled result changed");

endmodule

bind fuzzy_pd_temperature_controller_unit fpdc_checker u_fpdc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .drive        (out_ch.drive),
    .fuzzy_output (out_ch.fuzzy_output),
    .no_weight    (out_ch.no_weight),
    .clamped      (out_ch.clamped)
);
